### rtl/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types, constants and lookup tables of the reciprocal square root
// estimate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

  localparam int WORD_W  = 64;
  localparam int FRAC_W  = 52;
  localparam int EXP_W   = 11;
  localparam int WEXP_W  = 12;   // working exponent, two's complement
  localparam int SEG_W   = 13;   // leading-zero segment width
  localparam int SEG_N   = 4;
  localparam int BASE_W  = 26;
  localparam int STEP_W  = 11;
  localparam int LOW_W   = 11;
  localparam int PROD_W  = STEP_W + LOW_W;
  localparam int LZ_W    = 6;

  localparam logic [EXP_W-1:0]  EXP_ALL_ONES = 11'h7FF;
  localparam logic [WORD_W-1:0] QNAN_BITS    = 64'h7FF8_0000_0000_0000;
  localparam int                QUIET_POS    = 51;
  // 0x3FF plus 0x3FE plus 0x3FF, the new exponent is (this - e) / 2
  localparam logic [WEXP_W-1:0] EXP_BIAS2    = 12'hBFC;

  localparam logic [BASE_W-1:0] RSE_BASE [32] = '{
    26'h3ffa000, 26'h3c29000, 26'h38aa000, 26'h3572000, 26'h3279000,
    26'h2fb7000, 26'h2d26000, 26'h2ac0000, 26'h2881000, 26'h2665000,
    26'h2468000, 26'h2287000, 26'h20c1000, 26'h1f12000, 26'h1d79000,
    26'h1bf4000, 26'h1a7e800, 26'h17cb800, 26'h1552800, 26'h130c000,
    26'h10f2000, 26'h0eff000, 26'h0d2e000, 26'h0b7c000, 26'h09e5000,
    26'h0867000, 26'h06ff000, 26'h05ab800, 26'h046a000, 26'h0339800,
    26'h0218800, 26'h0105800
  };

  localparam logic [STEP_W-1:0] RSE_STEP [32] = '{
    11'h7a4, 11'h700, 11'h670, 11'h5f2, 11'h584, 11'h524, 11'h4cc, 11'h47e,
    11'h43a, 11'h3fa, 11'h3c2, 11'h38e, 11'h35e, 11'h332, 11'h30a, 11'h2e6,
    11'h568, 11'h4f3, 11'h48d, 11'h435, 11'h3e7, 11'h3a2, 11'h365, 11'h32e,
    11'h2fc, 11'h2d0, 11'h2a8, 11'h283, 11'h261, 11'h243, 11'h226, 11'h20b
  };

  // Decode stage: classification and per-segment leading-zero counts
  typedef struct packed {
    logic                      valid;
    logic                      special;
    logic [WORD_W-1:0]         special_bits;
    logic                      denorm;
    logic [EXP_W-1:0]          efield;
    logic [FRAC_W-1:0]         frac;
    logic [SEG_N-1:0]          seg_zero;
    logic [SEG_N-1:0][3:0]     seg_lz;
  } rse_dec_t;

  // Normalized operand handed to the interpolation stages
  typedef struct packed {
    logic                      valid;
    logic                      special;
    logic [WORD_W-1:0]         special_bits;
    logic [WEXP_W-1:0]         wexp;
    logic [FRAC_W-1:0]         frac;
  } rse_norm_t;

  // Table lookup and product stage
  typedef struct packed {
    logic                      valid;
    logic                      special;
    logic [WORD_W-1:0]         special_bits;
    logic [EXP_W-1:0]          newexp;
    logic [BASE_W-1:0]         base;
    logic [PROD_W-1:0]         prod;
  } rse_mul_t;

  // Leading zeros of a 13-bit segment, 13 when the segment is zero
  function automatic logic [3:0] rse_lz13(input logic [SEG_W-1:0] v);
    logic [3:0] cnt;
    cnt = 4'(SEG_W);
    for (int i = 0; i < SEG_W; i++) begin
      if (v[i]) begin
        cnt = 4'(SEG_W - 1 - i);
      end
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

### rtl/rse_in_if.sv
// ----------------------------------------------------------------------------
// rse_in_if
// Operand channel: valid/ready handshake carrying one double bit pattern.
// ----------------------------------------------------------------------------
`default_nettype none

interface rse_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] operand_bits;

  modport source (output valid, output operand_bits, input ready);
  modport sink   (input valid, input operand_bits, output ready);
endinterface

`default_nettype wire

### rtl/rse_out_if.sv
// ----------------------------------------------------------------------------
// rse_out_if
// Estimate channel: valid/ready handshake carrying one double bit pattern.
// ----------------------------------------------------------------------------
`default_nettype none

interface rse_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] estimate_bits;

  modport source (output valid, output estimate_bits, input ready);
  modport sink   (input valid, input estimate_bits, output ready);
endinterface

`default_nettype wire

### rtl/rse_norm.sv
// ----------------------------------------------------------------------------
// rse_norm
// Two pipeline stages: decode the operand and count leading zeros per
// segment, then combine the counts and normalize denormal fractions.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_norm
  import rse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [WORD_W-1:0] in_word,
  output      rse_norm_t         norm
);

  rse_dec_t  dec;
  rse_dec_t  dec_next;
  rse_norm_t norm_next;

  // Classify the word and pick the fixed results
  always_comb begin
    logic              sign;
    logic [EXP_W-1:0]  efield;
    logic [FRAC_W-1:0] frac;
    sign   = in_word[WORD_W-1];
    efield = in_word[WORD_W-2:FRAC_W];
    frac   = in_word[FRAC_W-1:0];

    dec_next.valid        = in_valid;
    dec_next.denorm       = (efield == '0);
    dec_next.efield       = efield;
    dec_next.frac         = frac;
    dec_next.special      = 1'b1;
    dec_next.special_bits = QNAN_BITS;
    priority if (efield == '0 && frac == '0) begin
      dec_next.special_bits = {sign, EXP_ALL_ONES, {FRAC_W{1'b0}}};
    end else if (efield == EXP_ALL_ONES && frac == '0) begin
      dec_next.special_bits = sign ? QNAN_BITS : '0;
    end else if (efield == EXP_ALL_ONES) begin
      dec_next.special_bits = in_word;
      dec_next.special_bits[QUIET_POS] = 1'b1;
    end else if (sign) begin
      dec_next.special_bits = QNAN_BITS;
    end else begin
      dec_next.special = 1'b0;
    end

    // Segment 0 holds the top fraction bits
    for (int s = 0; s < SEG_N; s++) begin
      dec_next.seg_zero[s] = (frac[FRAC_W-1-s*SEG_W -: SEG_W] == '0);
      dec_next.seg_lz[s]   = rse_lz13(frac[FRAC_W-1-s*SEG_W -: SEG_W]);
    end
  end

  // Combine segment counts, shift out the leading zeros and the hidden bit
  always_comb begin
    logic [LZ_W-1:0] lz;
    logic [LZ_W-1:0] sh;
    priority if (!dec.seg_zero[0]) begin
      lz = LZ_W'(dec.seg_lz[0]);
    end else if (!dec.seg_zero[1]) begin
      lz = LZ_W'(SEG_W) + LZ_W'(dec.seg_lz[1]);
    end else if (!dec.seg_zero[2]) begin
      lz = LZ_W'(2 * SEG_W) + LZ_W'(dec.seg_lz[2]);
    end else begin
      lz = LZ_W'(3 * SEG_W) + LZ_W'(dec.seg_lz[3]);
    end
    sh = lz + LZ_W'(1);

    norm_next.valid        = dec.valid;
    norm_next.special      = dec.special;
    norm_next.special_bits = dec.special_bits;
    if (dec.denorm) begin
      norm_next.wexp = WEXP_W'(0) - WEXP_W'(lz);
      norm_next.frac = dec.frac << sh;
    end else begin
      norm_next.wexp = {1'b0, dec.efield};
      norm_next.frac = dec.frac;
    end
  end

  // Advance both stages together, hold on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      dec.valid  <= 1'b0;
      norm.valid <= 1'b0;
    end else if (en) begin
      dec  <= dec_next;
      norm <= norm_next;
    end
  end

endmodule

`default_nettype wire

### rtl/rse_interp.sv
// ----------------------------------------------------------------------------
// rse_interp
// Two pipeline stages: table lookup with decrement product and exponent,
// then the interpolating subtract and assembly of the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_interp
  import rse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire rse_norm_t         norm,
  output      logic              out_valid,
  output      logic [WORD_W-1:0] out_word
);

  rse_mul_t          mul;
  rse_mul_t          mul_next;
  logic [WORD_W-1:0] word_next;

  // Look up base and decrement, multiply by the low fraction bits
  always_comb begin
    logic [4:0]          idx;
    logic [LOW_W-1:0]    low;
    logic [WEXP_W-1:0]   t;
    idx = {~norm.wexp[0], norm.frac[FRAC_W-1 -: 4]};
    low = norm.frac[FRAC_W-5 -: LOW_W];
    t   = EXP_BIAS2 - norm.wexp;

    mul_next.valid        = norm.valid;
    mul_next.special      = norm.special;
    mul_next.special_bits = norm.special_bits;
    mul_next.newexp       = t[WEXP_W-1:1];
    mul_next.base         = RSE_BASE[idx];
    mul_next.prod         = PROD_W'(RSE_STEP[idx]) * PROD_W'(low);
  end

  // Subtract the decrement and pack the word
  always_comb begin
    logic [BASE_W-1:0] f;
    f = mul.base - BASE_W'(mul.prod);
    if (mul.special) begin
      word_next = mul.special_bits;
    end else begin
      word_next = {1'b0, mul.newexp, f, {(FRAC_W-BASE_W){1'b0}}};
    end
  end

  // Advance both stages together, hold on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      mul.valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mul       <= mul_next;
      out_valid <= mul.valid;
      out_word  <= word_next;
    end
  end

endmodule

`default_nettype wire

### rtl/recip_sqrt_estimate_double_unit.sv
// ----------------------------------------------------------------------------
// recip_sqrt_estimate_double_unit
// Four register stages lie between operand accept and estimate valid.
// Throughput: one word per cycle while the output is not stalled; the four stages
// move together, set by the leading-zero count, the normalizing shift, the
// decrement multiply and the interpolating subtract, one per stage.
// A stalled output holds every stage. Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module recip_sqrt_estimate_double_unit
  import rse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  rse_in_if.sink    in_ch,
  rse_out_if.source out_ch
);

  logic      en;
  rse_norm_t norm;

  // Advance the pipeline whenever the output slot is free or being taken
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  rse_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_ch.valid),
    .in_word  (in_ch.operand_bits),
    .norm     (norm)
  );

  rse_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .norm      (norm),
    .out_valid (out_ch.valid),
    .out_word  (out_ch.estimate_bits)
  );

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the reciprocal square root estimate unit. A driver
// pushes double bit patterns in random bursts, a monitor predicts every
// estimate on acceptance and compares it with the word that comes out, while
// the output side stalls in changing patterns.
// ----------------------------------------------------------------------------

module tb_top;
  import rse_pkg::*;

  localparam int RANDOM_WORDS = 1100;
  localparam int MAX_PRINTS   = 20;

  // Operand families for the random part
  typedef enum logic [2:0] {
    OPD_NORMAL, OPD_NEAR_ONE, OPD_DENORM, OPD_ZERO_INF, OPD_NAN, OPD_NEGATIVE
  } operand_kind_t;

  // Output stall patterns
  typedef enum logic [1:0] {
    RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC
  } rx_mode_t;

  // Interpolation tables: base and decrement per segment and exponent parity
  localparam logic [25:0] RSQRT_BASE [32] = '{
    26'h3ffa000, 26'h3c29000, 26'h38aa000, 26'h3572000, 26'h3279000,
    26'h2fb7000, 26'h2d26000, 26'h2ac0000, 26'h2881000, 26'h2665000,
    26'h2468000, 26'h2287000, 26'h20c1000, 26'h1f12000, 26'h1d79000,
    26'h1bf4000, 26'h1a7e800, 26'h17cb800, 26'h1552800, 26'h130c000,
    26'h10f2000, 26'h0eff000, 26'h0d2e000, 26'h0b7c000, 26'h09e5000,
    26'h0867000, 26'h06ff000, 26'h05ab800, 26'h046a000, 26'h0339800,
    26'h0218800, 26'h0105800
  };

  localparam logic [10:0] RSQRT_STEP [32] = '{
    11'h7a4, 11'h700, 11'h670, 11'h5f2, 11'h584, 11'h524, 11'h4cc, 11'h47e,
    11'h43a, 11'h3fa, 11'h3c2, 11'h38e, 11'h35e, 11'h332, 11'h30a, 11'h2e6,
    11'h568, 11'h4f3, 11'h48d, 11'h435, 11'h3e7, 11'h3a2, 11'h365, 11'h32e,
    11'h2fc, 11'h2d0, 11'h2a8, 11'h283, 11'h261, 11'h243, 11'h226, 11'h20b
  };

  logic clk = 1'b0;
  logic rst;

  rse_in_if  in_ch ();
  rse_out_if out_ch ();

  recip_sqrt_estimate_double_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [63:0] operand_q [$];
  logic [63:0] estimate_q [$];
  int          drain_q [$];

  int       issued_cnt;
  int       checked_cnt;
  int       error_cnt;
  int       normal_cnt;
  int       denorm_cnt;
  int       special_cnt;
  int       burst_left;
  int       gap_left;
  int       rx_left;
  int       rx_phase;
  rx_mode_t rx_mode;
  logic     in_took;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bit-exact estimate of 1/sqrt(x) on a double pattern
  function automatic logic [63:0] rsqrt_estimate(input logic [63:0] x);
    logic        sgn;
    logic [10:0] efield;
    logic [52:0] mant;
    longint      wexp;
    logic [63:0] exp_word;
    logic [14:0] interp;
    logic [4:0]  idx;
    logic [31:0] frac_est;
    sgn    = x[63];
    efield = x[62:52];
    mant   = {1'b0, x[51:0]};
    if (efield == '0 && mant == '0) begin
      return {sgn, EXP_ALL_ONES, 52'b0};
    end
    if (efield == EXP_ALL_ONES) begin
      if (mant == '0) begin
        return sgn ? QNAN_BITS : 64'd0;
      end
      return x | (64'd1 << QUIET_POS);
    end
    if (sgn) begin
      return QNAN_BITS;
    end
    wexp = longint'(efield);
    // Normalize a denormal; the working exponent may go negative
    if (efield == '0) begin
      wexp = 1;
      do begin
        wexp = wexp - 1;
        mant = mant << 1;
      end while (!mant[52]);
    end
    exp_word = (64'h3FF << 52) - ($unsigned(wexp - 64'sd1022) << 51);
    interp   = mant[51:37];
    idx      = {~wexp[0], interp[14:11]};
    frac_est = 32'(RSQRT_BASE[idx]) - 32'(RSQRT_STEP[idx]) * 32'(interp[10:0]);
    return {1'b0, exp_word[62:52], frac_est[25:0], 26'b0};
  endfunction

  // Random operand, weighted toward finite positive values
  function automatic logic [63:0] random_operand();
    operand_kind_t kind;
    int            pick;
    int            lead;
    logic [63:0]   bits;
    pick = $urandom_range(0, 99);
    bits = {$urandom, $urandom};
    if (pick < 50)      kind = OPD_NORMAL;
    else if (pick < 65) kind = OPD_NEAR_ONE;
    else if (pick < 77) kind = OPD_DENORM;
    else if (pick < 83) kind = OPD_ZERO_INF;
    else if (pick < 91) kind = OPD_NAN;
    else                kind = OPD_NEGATIVE;
    case (kind)
      OPD_NORMAL: begin
        bits[63]    = 1'b0;
        bits[62:52] = 11'($urandom_range(1, 'h7FE));
      end
      OPD_NEAR_ONE: begin
        bits[63]    = 1'b0;
        bits[62:52] = 11'($urandom_range('h3F0, 'h40F));
      end
      OPD_DENORM: begin
        lead        = $urandom_range(0, 51);
        bits[63]    = 1'b0;
        bits[62:52] = '0;
        bits[51:0]  = bits[51:0] >> lead;
        bits[51 - lead] = 1'b1;
      end
      OPD_ZERO_INF: begin
        bits[62:52] = $urandom_range(0, 1) ? EXP_ALL_ONES : 11'd0;
        bits[51:0]  = '0;
      end
      OPD_NAN: begin
        bits[62:52] = EXP_ALL_ONES;
        if (bits[51:0] == '0) begin
          bits[$urandom_range(0, 51)] = 1'b1;
        end
      end
      default: begin
        bits[63] = 1'b1;
        if (bits[62:52] == EXP_ALL_ONES) begin
          bits[62:52] = 11'($urandom_range(0, 'h7FE));
        end
        if (bits[62:52] == '0 && bits[51:0] == '0) begin
          bits[0] = 1'b1;
        end
      end
    endcase
    return bits;
  endfunction

  // Print one mismatch line (capped) and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_cnt < MAX_PRINTS) begin
      $display("%0t ERROR %s: got %h, want %h", $realtime, what, got, want);
    end
    error_cnt++;
  endtask

  // Driver: present operand words in bursts, hold while not taken
  always @(negedge clk) begin : drive_operands
    logic        next_valid;
    logic [63:0] next_bits;
    next_valid = in_ch.valid;
    next_bits  = in_ch.operand_bits;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!in_ch.valid || in_took) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (drain_q.size() != 0 && issued_cnt == drain_q[0] &&
                   estimate_q.size() != 0) begin
        // hold off until the pipeline has drained
      end else if (operand_q.size() != 0) begin
        if (drain_q.size() != 0 && issued_cnt == drain_q[0]) begin
          void'(drain_q.pop_front());
        end
        next_bits  = operand_q.pop_front();
        next_valid = 1'b1;
        issued_cnt++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_ch.valid        <= next_valid;
    in_ch.operand_bits <= next_bits;
  end

  // Receiver: stall on a pattern that changes every so often
  always @(negedge clk) begin : drive_ready
    logic next_ready;
    if (rx_left <= 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 200);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:     next_ready = 1'b1;
      RX_RANDOM:   next_ready = 1'($urandom_range(0, 1));
      RX_SPARSE:   next_ready = ($urandom_range(0, 3) == 0);
      default:     next_ready = (rx_phase % 3 != 2);
    endcase
    out_ch.ready <= rst ? 1'b0 : next_ready;
  end

  // Monitor: predict on operand accept, check on estimate accept
  always @(posedge clk) begin : watch_channels
    logic [63:0] want;
    in_took = !rst && in_ch.valid && in_ch.ready;
    if (in_took) begin
      estimate_q.push_back(rsqrt_estimate(in_ch.operand_bits));
      if (in_ch.operand_bits[63] || in_ch.operand_bits[62:52] == EXP_ALL_ONES ||
          in_ch.operand_bits[62:0] == '0) begin
        special_cnt++;
      end else if (in_ch.operand_bits[62:52] == '0) begin
        denorm_cnt++;
      end else begin
        normal_cnt++;
      end
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (estimate_q.size() == 0) begin
        report_mismatch("unexpected estimate word", out_ch.estimate_bits, '0);
      end else begin
        want = estimate_q.pop_front();
        checked_cnt++;
        if (out_ch.estimate_bits !== want) begin
          report_mismatch("estimate_bits", out_ch.estimate_bits, want);
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [63:0] directed [$];
    in_ch.valid        = 1'b0;
    in_ch.operand_bits = '0;
    out_ch.ready       = 1'b0;
    rst         = 1'b1;
    in_took     = 1'b0;
    issued_cnt  = 0;
    checked_cnt = 0;
    error_cnt   = 0;
    normal_cnt  = 0;
    denorm_cnt  = 0;
    special_cnt = 0;
    burst_left  = 1;
    gap_left    = 0;
    rx_left     = 0;
    rx_phase    = 0;
    rx_mode     = RX_OPEN;

    // Signed zeros, infinities, quiet and signaling NaNs, negatives,
    // denormal extremes, normal extremes and both exponent parities
    directed = '{
      64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
      64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
      64'h7FF0_0000_0000_0001, 64'h7FF8_0000_0000_0000,
      64'hFFF7_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
      64'hBFF0_0000_0000_0000, 64'h8000_0000_0000_0001,
      64'hFFEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
      64'h0000_0000_0000_0003, 64'h0008_0000_0000_0000,
      64'h000F_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000,
      64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
      64'h4000_0000_0000_0000, 64'h3FE0_0000_0000_0000,
      64'h3FEF_FFFF_FFFF_FFFF, 64'h3FF8_0000_0000_0000,
      64'h3FFF_FFFF_FFFF_FFFF
    };
    foreach (directed[i]) begin
      operand_q.push_back(directed[i]);
    end
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      operand_q.push_back(random_operand());
    end
    // Drain the pipeline once after the directed words and once mid-run
    drain_q.push_back(directed.size());
    drain_q.push_back(directed.size() + RANDOM_WORDS / 2);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    do begin
      @(negedge clk);
    end while (operand_q.size() != 0 || in_ch.valid || estimate_q.size() != 0);
    repeat (10) @(posedge clk);
    if (estimate_q.size() != 0) begin
      report_mismatch("estimate words never delivered", '0, estimate_q[0]);
    end

    $display("Checked %0d estimates from %0d operands", checked_cnt, issued_cnt);
    $display("Operands: %0d normal, %0d denormal, %0d zero/inf/NaN/negative",
             normal_cnt, denorm_cnt, special_cnt);
    if (error_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
